### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int PRIO_W = 16;
   localparam int ECNT_W = 5;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast to every cell in the cycle of a transfer
   typedef struct packed {
      logic enq;
      logic deq;
      entry_type fresh;
   } cell_ctl_type;

endpackage

### rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Takes one enqueue or dequeue per clock cycle and returns its result from
// an output register in the following cycle; req_ready drops only while that
// register holds a result that has not been taken. Every cell compares its
// priority with the new entry in the same cycle and then keeps its entry,
// takes the new one, or shifts from a neighbor, so that rate holds whatever the
// fill level. Entries of equal priority leave in arrival order; an enqueue
// into a full queue is dropped and flagged as overflow.
module sorted_priority_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_data_in,
   input  logic signed [spq_pkg::PRIO_W-1:0]   req_priority_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_empty_flag,
   output logic [spq_pkg::ECNT_W-1:0]          rsp_entry_count
);

   logic [spq_pkg::CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [spq_pkg::DATA_W-1:0] data_out_ff, data_out_in;
   logic [1:0] status_ff, status_in;
   logic empty_ff, empty_in;
   logic [spq_pkg::ECNT_W-1:0] ecnt_ff, ecnt_in;

   logic accept, is_full, is_empty, enq_ok, deq_ok;
   spq_pkg::cell_ctl_type ctl;
   spq_pkg::entry_type cell_entry [spq_pkg::DEPTH];
   logic cell_behind [spq_pkg::DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign is_full = (count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH));
   assign is_empty = (count_ff == '0);
   assign enq_ok = accept && (req_operation == spq_pkg::OP_ENQ) && !is_full;
   assign deq_ok = accept && (req_operation == spq_pkg::OP_DEQ) && !is_empty;

   assign ctl.enq = enq_ok;
   assign ctl.deq = deq_ok;
   assign ctl.fresh.data = req_data_in;
   assign ctl.fresh.prio = req_priority_in;

   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      logic occ;
      logic prev_b;
      spq_pkg::entry_type prev_e, next_e;

      assign occ = (spq_pkg::CNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         assign prev_b = 1'b1;
         assign prev_e = '0;
      end else begin : g_body
         assign prev_b = cell_behind[i-1];
         assign prev_e = cell_entry[i-1];
      end
      if (i == spq_pkg::DEPTH - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_mid
         assign next_e = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ),
         .prev_behind (prev_b),
         .prev_entry  (prev_e),
         .next_entry  (next_e),
         .behind      (cell_behind[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + spq_pkg::CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - spq_pkg::CNT_W'(1);
      end

      data_out_in = deq_ok ? cell_entry[0].data : '0;
      if (req_operation == spq_pkg::OP_DEQ) begin
         status_in = is_empty ? spq_pkg::ST_UNDER : spq_pkg::ST_OK;
      end else begin
         status_in = is_full ? spq_pkg::ST_OVER : spq_pkg::ST_OK;
      end
      empty_in = (count_in == '0);
      ecnt_in = spq_pkg::ECNT_W'(count_in);

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_out_ff <= data_out_in;
         status_ff <= status_in;
         empty_ff <= empty_in;
         ecnt_ff <= ecnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_out = data_out_ff;
   assign rsp_status = status_ff;
   assign rsp_empty_flag = empty_ff;
   assign rsp_entry_count = ecnt_ff;

endmodule

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  logic                  prev_behind,
   input  spq_pkg::entry_type    prev_entry,
   input  spq_pkg::entry_type    next_entry,
   output logic                  behind,
   output spq_pkg::entry_type    entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new entry goes behind this occupied one when its priority is equal or larger
   assign behind = occupied && ($signed(entry_ff.prio) <= $signed(ctl.fresh.prio));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.deq) begin
         entry_in = next_entry;
      end else if (ctl.enq && !behind) begin
         if (prev_behind) begin
            entry_in = ctl.fresh;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [spq_pkg::DATA_W-1:0]   rsp_data_out,
   input logic [1:0]                          rsp_status,
   input logic                                rsp_empty_flag,
   input logic [spq_pkg::ECNT_W-1:0]          rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("result changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_empty_flag == (rsp_entry_count == '0))
      else $error("empty flag disagrees with entry count");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_UNDER |-> rsp_empty_flag)
      else $error("underflow reported on non-empty queue");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_OVER
         |-> rsp_entry_count == spq_pkg::ECNT_W'(spq_pkg::DEPTH))
      else $error("overflow reported on non-full queue");

   a_err_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != spq_pkg::ST_OK |-> rsp_data_out == '0)
      else $error("error result carries data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

### test/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking testbench for the min-first sorted priority queue.
// ----------------------------------------------------------------------------
// A queue of pending operations feeds a clocked driver that sends them in
// bursts with random gaps. A shadow sorted list predicts every result at the
// moment its request transfer happens, and the monitor compares each result
// transfer field by field with the oldest prediction. A short directed part
// covers underflow, priority and data extremes, FIFO order among equal
// priorities, filling to capacity and overflow. Random segments then lean
// toward enqueues, dequeues or neither so that the queue swings between
// full and empty. The receiver stalls on a changing pattern and once holds
// off for a long stretch.
module tb_sorted_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM  = 530;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_START  = 250;
   localparam int HOLD_LEN    = 150;

   typedef struct {
      logic                              op;
      logic signed [spq_pkg::DATA_W-1:0] data;
      logic signed [spq_pkg::PRIO_W-1:0] prio;
      bit                                wait_drain;
   } queue_op_type;

   typedef struct {
      logic signed [spq_pkg::DATA_W-1:0] data;
      logic [1:0]                        status;
      logic                              empty;
      logic [spq_pkg::ECNT_W-1:0]        count;
   } queue_rsp_type;

   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_type;
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_operation = spq_pkg::OP_ENQ;
   logic signed [spq_pkg::DATA_W-1:0] req_data_in = '0;
   logic signed [spq_pkg::PRIO_W-1:0] req_priority_in = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [spq_pkg::DATA_W-1:0] rsp_data_out;
   logic [1:0]                        rsp_status;
   logic                              rsp_empty_flag;
   logic [spq_pkg::ECNT_W-1:0]        rsp_entry_count;

   queue_op_type  pending_ops[$];
   queue_rsp_type expected_rsps[$];

   // shadow copy of the sorted entries, index 0 is the head
   logic signed [spq_pkg::DATA_W-1:0] shadow_data[spq_pkg::DEPTH];
   logic signed [spq_pkg::PRIO_W-1:0] shadow_prio[spq_pkg::DEPTH];
   int                                shadow_fill = 0;

   logic        req_took = 1'b0;
   int          errors = 0;
   int          cycle_count = 0;
   int          burst_left = 8;
   int          gap_left = 0;
   int          rx_cycle = 0;
   int          rx_mode_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   sorted_priority_queue DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_data_in     (req_data_in),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_empty_flag  (rsp_empty_flag),
      .rsp_entry_count (rsp_entry_count)
   );

   always #5ns clock = ~clock;

   // updates the shadow list and returns the result the block must give
   function automatic queue_rsp_type apply_queue_op(
      logic op,
      logic signed [spq_pkg::DATA_W-1:0] d,
      logic signed [spq_pkg::PRIO_W-1:0] p);
      queue_rsp_type r;
      int pos;
      r.data   = '0;
      r.status = spq_pkg::ST_OK;
      if (op == spq_pkg::OP_ENQ) begin
         if (shadow_fill >= spq_pkg::DEPTH) begin
            r.status = spq_pkg::ST_OVER;
         end else begin
            pos = 0;
            // behind every entry of equal priority
            while (pos < shadow_fill && shadow_prio[pos] <= p) pos++;
            for (int i = shadow_fill; i > pos; i--) begin
               shadow_data[i] = shadow_data[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_data[pos] = d;
            shadow_prio[pos] = p;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            r.status = spq_pkg::ST_UNDER;
         end else begin
            r.data = shadow_data[0];
            for (int i = 1; i < shadow_fill; i++) begin
               shadow_data[i-1] = shadow_data[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_fill--;
         end
      end
      r.empty = (shadow_fill == 0);
      r.count = shadow_fill[spq_pkg::ECNT_W-1:0];
      return r;
   endfunction

   task automatic add_op(logic op, logic [spq_pkg::DATA_W-1:0] d,
                         logic [spq_pkg::PRIO_W-1:0] p, bit hold);
      queue_op_type item;
      item.op         = op;
      item.data       = d;
      item.prio       = p;
      item.wait_drain = hold;
      pending_ops.push_back(item);
   endtask

   // driver: at most one nonblocking update of each input per falling edge
   always @(negedge clock) begin : driver
      logic         next_valid;
      queue_op_type item;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_took) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_ops.size() != 0 &&
                      !(pending_ops[0].wait_drain && expected_rsps.size() != 0)) begin
            item = pending_ops.pop_front();
            next_valid = 1'b1;
            req_operation   <= item.op;
            req_data_in     <= item.data;
            req_priority_in <= item.prio;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                      : $urandom_range(0, 3);
            end else begin
               burst_left--;
            end
         end
      end
      req_valid <= next_valid;
   end

   // receiver stall pattern, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 120);
         end else begin
            rx_mode_left--;
         end
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:     rsp_ready <= 1'b1;
               RX_HALF:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
               RX_PERIODIC: rsp_ready <= (rx_cycle % 5 != 0);
               default:     rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // monitor: check results, then predict the request transferred this edge
   always @(posedge clock) begin : monitor
      queue_rsp_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transfer");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data_out !== want.data) begin
                  $error("data_out: expected %0d, actual %0d", want.data, rsp_data_out);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_empty_flag !== want.empty) begin
                  $error("empty_flag: expected %0d, actual %0d", want.empty, rsp_empty_flag);
                  errors++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, actual %0d", want.count,
                         rsp_entry_count);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_queue_op(req_operation, req_data_in,
                                                   req_priority_in));
         req_took <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      mix_type mix;
      int      seg_len;
      int      enq_pct;
      int      made;
      logic    op;
      logic [spq_pkg::PRIO_W-1:0] p;

      // directed: underflow, extremes, ties, fill to capacity, overflow
      add_op(spq_pkg::OP_DEQ, 32'h0, 16'h0, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h8000_0000, 16'h8000, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h0000_0000, 16'h0000, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'hFFFF_FFFF, 16'h0000, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h0000_0001, 16'h0000, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h1234_5678, 16'h0005, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h8765_4321, 16'h0005, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'hAAAA_5555, 16'hFFFF, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h5555_AAAA, 16'h7FFF, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'hDEAD_BEEF, 16'h8000, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h0F0F_0F0F, 16'h0064, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'hF0F0_F0F0, 16'h0064, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h0000_0007, 16'h0007, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'hFFFF_FFF9, 16'hFFF9, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h0BAD_F00D, 16'h0001, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'h7FFF_0000, 16'h0000, 1'b0);
      add_op(spq_pkg::OP_ENQ, 32'hC0DE_C0DE, 16'h8000, 1'b0);
      repeat (6) add_op(spq_pkg::OP_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);

      // random segments, each leaning toward filling, draining or neither
      made = 0;
      while (made < NUM_RANDOM) begin
         mix = mix_type'($urandom_range(0, 2));
         seg_len = $urandom_range(10, 40);
         enq_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
         for (int k = 0; k < seg_len && made < NUM_RANDOM; k++) begin
            op = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
            case ($urandom_range(0, 3))
               0:       p = 16'($urandom_range(0, 4) - 2);   // dense ties near zero
               1:       p = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               default: p = 16'($urandom);
            endcase
            // pause the sender until everything is back, twice
            add_op(op, $urandom, p, made == 0 || made == NUM_RANDOM / 2);
            made++;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
test/tb_sorted_priority_queue.sv
